>>> hw/rtl/trivariate_polynomial_eval_macros.svh
// Assertion macros shared by the checker
`ifndef TRIVARIATE_POLYNOMIAL_EVAL_MACROS_SVH
`define TRIVARIATE_POLYNOMIAL_EVAL_MACROS_SVH
// implication checked every clock outside reset
`define TPE_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("tpe check failed");
// next-cycle implication
`define TPE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("tpe check failed");
`endif

>>> hw/rtl/tpe_pkg.sv
package tpe_pkg;
	localparam int MAX_DEGREE_DEF = 5;
	localparam int CFG_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE_Z = 2'd2;
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	typedef struct packed {
		logic               func;
		logic [7:0]         coef_index;
		logic signed [47:0] coef_value;
		logic signed [31:0] x_coord;
		logic signed [31:0] y_coord;
		logic signed [31:0] z_coord;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] poly_value;
		logic signed [63:0] grad_x;
		logic signed [63:0] grad_y;
		logic signed [63:0] grad_z;
		logic               saturated;
	} out_word_t;

	// queued command from front to back
	typedef struct packed {
		logic               is_eval;
		logic [7:0]         addr;
		logic signed [47:0] coef;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} cmd_t;

	// clamp a Q1.30 coordinate to plus or minus one
	function automatic logic signed [31:0] clamp_coord(input logic signed [31:0] c);
		logic signed [31:0] r;
		r = c;
		if (c > 32'sd1073741824) r = 32'sd1073741824;
		if (c < -32'sd1073741824) r = -32'sd1073741824;
		return r;
	endfunction

	// 64-bit saturating add
	function automatic logic [64:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
		if (s < -65'sh0_8000_0000_0000_0000) return {1'b1, 64'h8000_0000_0000_0000};
		return {1'b0, s[63:0]};
	endfunction
endpackage

>>> hw/rtl/tpe_front.sv
// Front: accepts words, clamps coordinates and queues commands
module tpe_front import tpe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_word_t in_word,
	input  logic     in_valid,
	output logic     in_ready,
	output cmd_t     cmd,
	output logic     cmd_valid,
	input  logic     cmd_ready
);
	localparam int DEPTH = 2;
	cmd_t q_q [DEPTH];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	cmd_t c_in;

	always_comb begin
		c_in.is_eval = (in_word.func == FUNC_EVAL);
		c_in.addr = in_word.coef_index;
		c_in.coef = in_word.coef_value;
		c_in.x = clamp_coord(in_word.x_coord);
		c_in.y = clamp_coord(in_word.y_coord);
		c_in.z = clamp_coord(in_word.z_coord);
	end

	assign in_ready = (cnt_q != 2'(DEPTH));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rd_q];

	// two-entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (cmd_valid && cmd_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(cmd_valid && cmd_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) q_q[wr_q] <= c_in;
	end
endmodule

>>> hw/rtl/tpe_back.sv
// Back: coefficient memory and a sequenced multiply-accumulate engine
module tpe_back import tpe_pkg::*; #(
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  logic [CFG_W-1:0] deg_x,
	input  logic [CFG_W-1:0] deg_y,
	input  logic [CFG_W-1:0] deg_z,
	output out_word_t        out_word,
	output logic             out_valid,
	input  logic             out_ready
);
	localparam int DIM = MAX_DEGREE + 1;
	localparam int SIZE = DIM * DIM * DIM;
	localparam int AW = $clog2(SIZE);
	localparam int DW = $clog2(DIM + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_POW, S_POW2, S_RD, S_MA, S_MB, S_MC, S_MD, S_CA, S_CB,
		S_ACC, S_NEXT, S_OUT
	} state_t;

	state_t state_q;
	logic signed [47:0] mem [SIZE];
	logic signed [47:0] rdata_q;
	logic [AW-1:0] clr_q;
	cmd_t c_q;
	logic signed [31:0] px_q [DIM];
	logic signed [31:0] py_q [DIM];
	logic signed [31:0] pz_q [DIM];
	logic [DW-1:0] n_q;
	logic [DW-1:0] dx_q, dy_q, dz_q;
	logic [DW-1:0] i_q, j_q, k_q;
	logic [1:0] t_q;              // 0 value, 1 gx, 2 gy, 3 gz
	logic signed [31:0] ma_q, mb_q, mc_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] mono_q;
	logic signed [79:0] hi_q, lo_q;
	logic signed [63:0] acc_q [4];
	logic sat_q;
	out_word_t out_q;
	logic ovalid_q;

	// clamp degree register to the table size
	function automatic logic [DW-1:0] cdeg(input logic [CFG_W-1:0] d);
		if (32'(d) > MAX_DEGREE) return DW'(MAX_DEGREE);
		return DW'(d);
	endfunction

	// floor((p + 2^29) / 2^30)
	function automatic logic signed [63:0] rnd30(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = p + 64'sd536870912;
		return s >>> 30;
	endfunction

	logic [AW-1:0] addr;
	logic [DW-1:0] ei, ej, ek;
	logic term_ok;
	logic signed [63:0] term;
	logic [64:0] sa;
	logic signed [79:0] cm_sum;

	assign addr = AW'((32'(i_q) * DIM + 32'(j_q)) * DIM + 32'(k_q));
	always_comb begin
		ei = i_q; ej = j_q; ek = k_q;
		term_ok = 1'b1;
		case (t_q)
			2'd1: begin ei = i_q - 1'b1; term_ok = (i_q != '0); end
			2'd2: begin ej = j_q - 1'b1; term_ok = (j_q != '0); end
			2'd3: begin ek = k_q - 1'b1; term_ok = (k_q != '0); end
			default: ;
		endcase
	end
	assign cm_sum = hi_q + lo_q;

	always_comb begin
		case (t_q)
			2'd1: term = cm_sum[63:0] * $signed({1'b0, i_q});
			2'd2: term = cm_sum[63:0] * $signed({1'b0, j_q});
			2'd3: term = cm_sum[63:0] * $signed({1'b0, k_q});
			default: term = cm_sum[63:0];
		endcase
		sa = sat_add(acc_q[t_q], term);
	end

	// the result register parts the engine from the output channel
	assign cmd_ready = (state_q == S_IDLE);
	assign out_word = out_q;
	assign out_valid = ovalid_q;

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) mem[clr_q] <= '0;
		else if (state_q == S_IDLE && cmd_valid && cmd_ready && !cmd.is_eval
			&& 32'(cmd.addr) < SIZE)
			mem[AW'(cmd.addr)] <= cmd.coef;
		rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			ovalid_q <= 1'b0;
			c_q <= '0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == SIZE - 1) state_q <= S_IDLE;
				end
				S_IDLE: if (cmd_valid && cmd_ready) begin
					c_q <= cmd;
					if (cmd.is_eval) begin
						dx_q <= cdeg(deg_x); dy_q <= cdeg(deg_y); dz_q <= cdeg(deg_z);
						px_q[0] <= 32'sd1073741824; py_q[0] <= 32'sd1073741824;
						pz_q[0] <= 32'sd1073741824;
						n_q <= DW'(1);
						state_q <= S_POW;
					end
				end
				// one power per axis in each pass through S_POW and S_POW2
				S_POW: begin
					px_q[n_q] <= 32'(rnd30(64'(px_q[n_q-1]) * 64'(c_q.x)));
					py_q[n_q] <= 32'(rnd30(64'(py_q[n_q-1]) * 64'(c_q.y)));
					pz_q[n_q] <= 32'(rnd30(64'(pz_q[n_q-1]) * 64'(c_q.z)));
					state_q <= S_POW2;
				end
				S_POW2: begin
					if (32'(n_q) == DIM - 1) begin
						i_q <= '0; j_q <= '0; k_q <= '0; t_q <= 2'd0;
						acc_q[0] <= '0; acc_q[1] <= '0; acc_q[2] <= '0; acc_q[3] <= '0;
						sat_q <= 1'b0;
						state_q <= S_RD;
					end else begin
						n_q <= n_q + 1'b1;
						state_q <= S_POW;
					end
				end
				S_RD: begin
					ma_q <= px_q[ei]; mb_q <= py_q[ej]; mc_q <= pz_q[ek];
					state_q <= S_MA;
				end
				S_MA: begin
					prod_q <= 64'(ma_q) * 64'(mb_q);
					state_q <= S_MB;
				end
				S_MB: begin
					prod_q <= 64'(32'(rnd30(prod_q))) * 64'(mc_q);
					state_q <= S_MC;
				end
				S_MC: begin
					mono_q <= 32'(rnd30(prod_q));
					state_q <= S_MD;
				end
				// coefficient times monomial in two halves
				S_MD: begin
					hi_q <= 80'(rdata_q >>> 16) * 80'(mono_q);
					lo_q <= 80'($signed({1'b0, rdata_q[15:0]})) * 80'(mono_q);
					state_q <= S_CA;
				end
				S_CA: begin
					hi_q <= hi_q <<< 16;
					lo_q <= lo_q + 80'sd536870912;
					state_q <= S_CB;
				end
				S_CB: begin
					hi_q <= (hi_q + lo_q) >>> 30;
					lo_q <= '0;
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (term_ok) begin
						acc_q[t_q] <= sa[63:0];
						if (sa[64]) sat_q <= 1'b1;
					end
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					t_q <= t_q + 1'b1;
					state_q <= S_RD;
					if (t_q == 2'd3) begin
						if (k_q != dz_q) k_q <= k_q + 1'b1;
						else begin
							k_q <= '0;
							if (j_q != dy_q) j_q <= j_q + 1'b1;
							else begin
								j_q <= '0;
								if (i_q != dx_q) i_q <= i_q + 1'b1;
								else state_q <= S_OUT;
							end
						end
					end
				end
				S_OUT: if (!ovalid_q) begin
					out_q.poly_value <= acc_q[0];
					out_q.grad_x <= acc_q[1];
					out_q.grad_y <= acc_q[2];
					out_q.grad_z <= acc_q[3];
					out_q.saturated <= sat_q;
					ovalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> hw/rtl/trivariate_polynomial_eval.sv
// Trivariate polynomial evaluator with gradient. A load word (func 0) writes
// one 48-bit coefficient; an evaluate word (func 1) returns value and x/y/z
// derivatives. After the input queue, an evaluation first computes the
// coordinate powers for each axis, then one shared multiply chain handles
// four terms per coefficient in turn. After reset a clearing pass zeroes all
// (MAX_DEGREE+1)^3 table entries before any command is processed; the front
// queue can still take words meanwhile. Degree registers may be written at
// any time while the block is idle.
module trivariate_polynomial_eval import tpe_pkg::*; #(
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  in_word_t             in_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	output out_word_t            out_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);
	cmd_t cmd;
	logic cmd_valid, cmd_ready;
	logic [CFG_W-1:0] deg_x_q, deg_y_q, deg_z_q;

	// degree registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_x_q <= CFG_W'(5);
			deg_y_q <= CFG_W'(5);
			deg_z_q <= CFG_W'(5);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEGREE_X: deg_x_q <= cfg_data;
				REG_DEGREE_Y: deg_y_q <= cfg_data;
				REG_DEGREE_Z: deg_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tpe_front u_front (
		.clk, .arst_n, .in_word(in_data), .in_valid, .in_ready,
		.cmd, .cmd_valid, .cmd_ready
	);

	tpe_back #(.MAX_DEGREE(MAX_DEGREE)) u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_ready,
		.deg_x(deg_x_q), .deg_y(deg_y_q), .deg_z(deg_z_q),
		.out_word(out_data), .out_valid, .out_ready
	);
endmodule

>>> hw/rtl/tpe_checker.sv
`include "trivariate_polynomial_eval_macros.svh"
// Port-level checks
module tpe_checker import tpe_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input in_word_t  in_data,
	input logic      in_valid,
	input logic      in_ready,
	input out_word_t out_data,
	input logic      out_valid,
	input logic      out_ready
);
	`TPE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`TPE_ASSERT_NEXT(a_out_drop, clk, arst_n, out_valid && out_ready, !out_valid)
	`TPE_ASSERT_IMP(a_out_known, clk, arst_n, out_valid, !$isunknown(out_data))
	`TPE_ASSERT_IMP(a_in_known, clk, arst_n, in_valid, !$isunknown(in_data))
	`TPE_ASSERT_IMP(a_ctrl_known, clk, arst_n, 1'b1, !$isunknown(in_ready) && !$isunknown(out_valid))
endmodule

bind trivariate_polynomial_eval tpe_checker u_chk (
	.clk, .arst_n, .in_data, .in_valid, .in_ready, .out_data, .out_valid, .out_ready
);
